// ----- hw/rtl/alu65_pkg.sv -----
// alu65_pkg: types, opcode codes and constants for the 8-bit execute unit
// no dependencies
package alu65_pkg;

  localparam int OpW = 7;

  typedef struct packed {
    logic [6:0]  opcode;
    logic [7:0]  data_in;
    logic [15:0] address_in;
  } alu65_in_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  stack_out;
    logic [7:0]  status_out;
    logic [7:0]  data_out;
    logic [15:0] address_out;
    logic        branch_taken;
  } alu65_out_t;

  // architectural registers
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [7:0] p;
  } alu65_regs_t;

  localparam logic [7:0] FlagC = 8'h01;
  localparam logic [7:0] FlagZ = 8'h02;
  localparam logic [7:0] FlagI = 8'h04;
  localparam logic [7:0] FlagD = 8'h08;
  localparam logic [7:0] FlagV = 8'h40;
  localparam logic [7:0] FlagN = 8'h80;
  localparam logic [7:0] PMask = 8'hcf;
  localparam logic [7:0] PFixed = 8'h30;

  localparam logic [6:0] OP_ADC = 7'd0,  OP_AND = 7'd1,  OP_ASLA = 7'd2, OP_ASLM = 7'd3;
  localparam logic [6:0] OP_BIT = 7'd4,  OP_CLC = 7'd5,  OP_CLD = 7'd6,  OP_CLI = 7'd7;
  localparam logic [6:0] OP_CLV = 7'd8,  OP_CMP = 7'd9,  OP_CPX = 7'd10, OP_CPY = 7'd11;
  localparam logic [6:0] OP_DEC = 7'd12, OP_DEX = 7'd13, OP_DEY = 7'd14, OP_EOR = 7'd15;
  localparam logic [6:0] OP_INC = 7'd16, OP_INX = 7'd17, OP_INY = 7'd18, OP_LDA = 7'd19;
  localparam logic [6:0] OP_LDX = 7'd20, OP_LDY = 7'd21, OP_LSRA = 7'd22, OP_LSRM = 7'd23;
  localparam logic [6:0] OP_NOP = 7'd24, OP_ORA = 7'd25, OP_ROLA = 7'd26, OP_ROLM = 7'd27;
  localparam logic [6:0] OP_RORA = 7'd28, OP_RORM = 7'd29, OP_SBC = 7'd30, OP_SEC = 7'd31;
  localparam logic [6:0] OP_SED = 7'd32, OP_SEI = 7'd33, OP_STA = 7'd34, OP_STX = 7'd35;
  localparam logic [6:0] OP_STY = 7'd36, OP_TAX = 7'd37, OP_TAY = 7'd38, OP_TSX = 7'd39;
  localparam logic [6:0] OP_TXA = 7'd40, OP_TXS = 7'd41, OP_TYA = 7'd42, OP_ANC = 7'd43;
  localparam logic [6:0] OP_SAX = 7'd44, OP_ANE = 7'd45, OP_ARR = 7'd46, OP_ASR = 7'd47;
  localparam logic [6:0] OP_ATX = 7'd48, OP_AXS = 7'd49, OP_DCP = 7'd50, OP_ISC = 7'd51;
  localparam logic [6:0] OP_LAS = 7'd52, OP_LAX = 7'd53, OP_RLA = 7'd54, OP_RRA = 7'd55;
  localparam logic [6:0] OP_SLO = 7'd56, OP_SRE = 7'd57, OP_SXA = 7'd58, OP_SYA = 7'd59;
  localparam logic [6:0] OP_TAS = 7'd60, OP_BCC = 7'd61, OP_BCS = 7'd62, OP_BEQ = 7'd63;
  localparam logic [6:0] OP_BMI = 7'd64, OP_BNE = 7'd65, OP_BPL = 7'd66, OP_BVC = 7'd67;
  localparam logic [6:0] OP_BVS = 7'd68, OP_PLP = 7'd69;

endpackage

// ----- hw/rtl/alu65_adder.sv -----
// alu65_adder: binary/decimal add with carry, flags for add and subtract
// depends on alu65_pkg
module alu65_adder
  import alu65_pkg::*;
(
  input  logic [7:0] a,
  input  logic [7:0] i,
  input  logic       cin,
  input  logic       dec,
  input  logic       sub,
  output logic [7:0] sum,
  output logic       c_flag,
  output logic       z_flag,
  output logic       v_flag,
  output logic       n_flag
);

  logic [8:0] bin;
  logic [5:0] lo;
  logic       cl;
  logic [9:0] hi;
  logic [9:0] adj;

  always_comb begin
    bin = {1'b0, a} + {1'b0, i} + {8'd0, cin};
    lo  = {2'b0, a[3:0]} + {2'b0, i[3:0]} + {5'd0, cin};
    // low nibble decimal correction, sixth bit keeps the carry out of +6
    if (sub) begin
      cl = lo > 6'h0f;
      if (!cl) lo = lo - 6'h06;
    end else begin
      if (lo > 6'h09) lo = lo + 6'h06;
      cl = lo > 6'h0f;
    end
    hi = {2'b0, a[7:4], 4'h0} + {2'b0, i[7:4], 4'h0} + {5'd0, cl, 4'h0}
         + {6'd0, lo[3:0]};
    adj = hi;
    if (sub) begin
      if (!(hi > 10'h0ff)) adj = hi - 10'h060;
    end else if (hi > 10'h09f) begin
      adj = hi + 10'h060;
    end
    z_flag = bin[7:0] == 8'h00;
    if (!dec) begin
      sum    = bin[7:0];
      c_flag = bin[8];
      v_flag = ~(a[7] ^ i[7]) & (a[7] ^ bin[7]);
      n_flag = bin[7];
    end else begin
      sum    = adj[7:0];
      c_flag = sub ? (hi > 10'h0ff) : (adj > 10'h0ff);
      v_flag = ~(a[7] ^ i[7]) & (a[7] ^ hi[7]);
      n_flag = hi[7];
    end
  end

endmodule

// ----- hw/rtl/eight_bit_cpu_alu_execute.sv -----
// Execute unit of an 8-bit processor: one operation per clock unless the result
// side stalls. An accepted request is decoded and executed against the register
// file in a single combinational pass, and the result lands in an output
// register the next cycle. A new request is taken every cycle while the output
// register is empty or being drained. The register file updates on accept, so
// back-to-back requests see each other's results.
// depends on alu65_pkg, alu65_adder
module eight_bit_cpu_alu_execute
  import alu65_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  alu65_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output alu65_out_t out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  alu65_regs_t regs_r, regs_nxt;
  logic        dec_en_r;
  logic        out_valid_r;
  alu65_out_t  out_r, out_nxt;
  logic        acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // operand choice for the shared adder
  logic [6:0] op;
  logic [7:0] m, p;
  logic [7:0] ad_i, ad_sum;
  logic       ad_sub, ad_c, ad_z, ad_v, ad_n;
  logic       c_in;

  assign op   = in_data.opcode;
  assign m    = in_data.data_in;
  assign p    = regs_r.p;
  assign c_in = p[0];

  always_comb begin
    ad_sub = 1'b0;
    ad_i   = m;
    case (op)
      OP_SBC: begin
        ad_sub = 1'b1;
        ad_i   = ~m;
      end
      OP_ISC: begin
        ad_sub = 1'b1;
        ad_i   = ~(m + 8'd1);
      end
      OP_RRA: ad_i = {c_in, m[7:1]};
      default: ad_i = m;
    endcase
  end

  alu65_adder u_adder (
    .a      (regs_r.a),
    .i      (ad_i),
    .cin    (op == OP_RRA ? m[0] : c_in),
    .dec    (dec_en_r && p[3]),
    .sub    (ad_sub),
    .sum    (ad_sum),
    .c_flag (ad_c),
    .z_flag (ad_z),
    .v_flag (ad_v),
    .n_flag (ad_n)
  );

  // main decode
  logic [7:0]  a, x, y, s, f, d, t, res;
  logic [15:0] ad;
  logic        tk, zn;
  logic [8:0]  cmp;
  logic [15:0] tas_d;

  always_comb begin
    a = regs_r.a; x = regs_r.x; y = regs_r.y; s = regs_r.s; f = p;
    d = m; ad = in_data.address_in; tk = 1'b0; zn = 1'b0; res = 8'h00;
    cmp = 9'd0; t = 8'h00;
    tas_d = in_data.address_in - {8'd0, regs_r.y};
    case (op)
      OP_ADC, OP_SBC, OP_ISC, OP_RRA: begin
        if (op == OP_ISC) d = m + 8'd1;
        if (op == OP_RRA) d = {c_in, m[7:1]};
        a = ad_sum;
        f[0] = (op == OP_RRA && !(dec_en_r && p[3])) ? ad_c : ad_c;
        f[1] = ad_z; f[6] = ad_v; f[7] = ad_n;
      end
      OP_AND: begin a = a & m; res = a; zn = 1'b1; end
      OP_ASLA: begin f[0] = a[7]; a = {a[6:0], 1'b0}; res = a; zn = 1'b1; end
      OP_ASLM: begin f[0] = m[7]; d = {m[6:0], 1'b0}; res = d; zn = 1'b1; end
      OP_BIT: begin f[1] = (a & m) == 8'h00; f[6] = m[6]; f[7] = m[7]; end
      OP_CLC: f[0] = 1'b0;
      OP_CLD: f[3] = 1'b0;
      OP_CLI: f[2] = 1'b0;
      OP_CLV: f[6] = 1'b0;
      OP_CMP, OP_CPX, OP_CPY, OP_DCP: begin
        if (op == OP_DCP) d = m - 8'd1;
        t = (op == OP_CPX) ? x : (op == OP_CPY) ? y : a;
        cmp = {1'b0, t} - {1'b0, d};
        f[0] = !cmp[8]; res = cmp[7:0]; zn = 1'b1;
      end
      OP_DEC: begin d = m - 8'd1; res = d; zn = 1'b1; end
      OP_DEX: begin x = x - 8'd1; res = x; zn = 1'b1; end
      OP_DEY: begin y = y - 8'd1; res = y; zn = 1'b1; end
      OP_EOR: begin a = a ^ m; res = a; zn = 1'b1; end
      OP_INC: begin d = m + 8'd1; res = d; zn = 1'b1; end
      OP_INX: begin x = x + 8'd1; res = x; zn = 1'b1; end
      OP_INY: begin y = y + 8'd1; res = y; zn = 1'b1; end
      OP_LDA: begin a = m; res = m; zn = 1'b1; end
      OP_LDX: begin x = m; res = m; zn = 1'b1; end
      OP_LDY: begin y = m; res = m; zn = 1'b1; end
      OP_LSRA: begin f[0] = a[0]; a = {1'b0, a[7:1]}; res = a; zn = 1'b1; end
      OP_LSRM: begin f[0] = m[0]; d = {1'b0, m[7:1]}; res = d; zn = 1'b1; end
      OP_ORA: begin a = a | m; res = a; zn = 1'b1; end
      OP_ROLA: begin f[0] = a[7]; a = {a[6:0], c_in}; res = a; zn = 1'b1; end
      OP_ROLM: begin f[0] = m[7]; d = {m[6:0], c_in}; res = d; zn = 1'b1; end
      OP_RORA: begin f[0] = a[0]; a = {c_in, a[7:1]}; res = a; zn = 1'b1; end
      OP_RORM: begin f[0] = m[0]; d = {c_in, m[7:1]}; res = d; zn = 1'b1; end
      OP_SEC: f[0] = 1'b1;
      OP_SED: f[3] = 1'b1;
      OP_SEI: f[2] = 1'b1;
      OP_STA: d = a;
      OP_STX: d = x;
      OP_STY: d = y;
      OP_TAX: begin x = a; res = a; zn = 1'b1; end
      OP_TAY: begin y = a; res = a; zn = 1'b1; end
      OP_TSX: begin x = s; res = s; zn = 1'b1; end
      OP_TXA: begin a = x; res = x; zn = 1'b1; end
      OP_TXS: s = x;
      OP_TYA: begin a = y; res = y; zn = 1'b1; end
      OP_ANC: begin a = a & m; f[0] = a[7]; res = a; zn = 1'b1; end
      OP_SAX: d = a & x;
      OP_ANE: begin a = x & m; res = a; zn = 1'b1; end
      OP_ARR: begin
        a = {c_in, a[7:1] & m[7:1]};
        f[0] = a[6]; f[6] = a[6] ^ a[5]; res = a; zn = 1'b1;
      end
      OP_ASR: begin
        t = a & m; f[0] = t[0]; a = {1'b0, t[7:1]}; res = a; zn = 1'b1;
      end
      OP_ATX: begin a = m; x = m; res = m; zn = 1'b1; end
      OP_AXS: begin
        cmp = {1'b0, x & a} - {1'b0, m};
        f[0] = !cmp[8]; x = cmp[7:0]; res = x; zn = 1'b1;
      end
      OP_LAS: begin
        t = m & s; s = t; a = t; x = t; res = t; zn = 1'b1;
      end
      OP_LAX: begin a = m; x = m; res = m; zn = 1'b1; end
      OP_RLA: begin
        f[0] = m[7]; d = {m[6:0], c_in}; a = a & d; res = a; zn = 1'b1;
      end
      OP_SLO: begin
        f[0] = m[7]; d = {m[6:0], 1'b0}; a = a | d; res = a; zn = 1'b1;
      end
      OP_SRE: begin
        f[0] = m[0]; d = {1'b0, m[7:1]}; a = a ^ d; res = a; zn = 1'b1;
      end
      OP_SXA, OP_SYA: begin
        t = ((op == OP_SXA) ? x : y) & (in_data.address_in[15:8] + 8'd1);
        ad = {t, in_data.address_in[7:0]};
        d = t;
      end
      OP_TAS: begin
        s = a & x;
        d = a & x & (tas_d[15:8] + 8'd1);
      end
      OP_BCC: tk = !p[0];
      OP_BCS: tk = p[0];
      OP_BEQ: tk = p[1];
      OP_BMI: tk = p[7];
      OP_BNE: tk = !p[1];
      OP_BPL: tk = !p[7];
      OP_BVC: tk = !p[6];
      OP_BVS: tk = p[6];
      OP_PLP: f = m & PMask;
      default: ;
    endcase
    if (zn) begin
      f[1] = res == 8'h00;
      f[7] = res[7];
    end
    regs_nxt = '{a: a, x: x, y: y, s: s, p: f & PMask};
    out_nxt.acc_out      = a;
    out_nxt.x_out        = x;
    out_nxt.y_out        = y;
    out_nxt.stack_out    = s;
    out_nxt.status_out   = (f & PMask) | PFixed;
    out_nxt.data_out     = d;
    out_nxt.address_out  = ad;
    out_nxt.branch_taken = tk;
  end

  // register file and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r      <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: 8'hff, p: FlagI};
      dec_en_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) dec_en_r <= cfg_data;
      if (acc) begin
        regs_r      <= regs_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (acc) out_r <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  // stalled result must not be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken over a stalled result");
  // accepted request always produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted request lost");
  // fixed status bits always set
  a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status_out[5] && out_data.status_out[4])
    else $error("status bits 5 and 4 not set");
  // register file holds without a request
  a_regs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(regs_r))
    else $error("register file changed without request");
`endif

endmodule

// ----- bench/eight_bit_cpu_alu_execute_tb.sv -----
// testbench for the 8-bit execute unit: random and directed requests, with a
// scoreboard that predicts registers, flags, write-back byte, address and branch
// depends on alu65_pkg and eight_bit_cpu_alu_execute
`timescale 1ns / 1ps

class alu65_scoreboard;
  logic [7:0] acc, rx, ry, sp, flags;
  logic       dec_en;
  alu65_pkg::alu65_out_t pending[$];
  int errors;

  function new();
    reset_state();
    errors = 0;
  endfunction

  function void reset_state();
    acc = 8'h00; rx = 8'h00; ry = 8'h00; sp = 8'hff;
    flags = alu65_pkg::FlagI; dec_en = 1'b1;
  endfunction

  function void put(logic [7:0] mask, logic on);
    flags = on ? (flags | mask) : (flags & ~mask);
  endfunction

  function logic get(logic [7:0] mask);
    return (flags & mask) != 0;
  endfunction

  function void set_zn(logic [7:0] v);
    put(alu65_pkg::FlagZ, v == 0);
    put(alu65_pkg::FlagN, v[7]);
  endfunction

  // binary or decimal add; subtract passes the inverted operand
  function void add_with_carry(logic [7:0] i, logic sub);
    logic [8:0] o;
    logic [9:0] w;
    logic [5:0] lo;
    logic cl, ch;
    logic [7:0] a;
    a = acc;
    o = a + i + get(alu65_pkg::FlagC);
    if (!dec_en || !get(alu65_pkg::FlagD)) begin
      put(alu65_pkg::FlagC, o[8]);
      set_zn(o[7:0]);
      put(alu65_pkg::FlagV, (~(a ^ i) & (a ^ o[7:0]) & 8'h80) != 0);
      acc = o[7:0];
    end else begin
      put(alu65_pkg::FlagZ, o[7:0] == 0);
      lo = a[3:0] + i[3:0] + get(alu65_pkg::FlagC);
      if (sub) begin
        cl = lo > 6'h0f;
        if (!cl) lo = lo - 6'h06;
      end else begin
        if (lo > 6'h09) lo = lo + 6'h06;
        cl = lo > 6'h0f;
      end
      w = {2'b0, a[7:4], 4'h0} + {2'b0, i[7:4], 4'h0} + (cl ? 10'h10 : 10'h0) + lo[3:0];
      put(alu65_pkg::FlagN, w[7]);
      put(alu65_pkg::FlagV, (~(a ^ i) & (a ^ w[7:0]) & 8'h80) != 0);
      if (sub) begin
        ch = w > 10'hff;
        if (!ch) w = w - 10'h60;
        put(alu65_pkg::FlagC, ch);
      end else begin
        if (w > 10'h9f) w = w + 10'h60;
        put(alu65_pkg::FlagC, w > 10'hff);
      end
      acc = w[7:0];
    end
  endfunction

  function void compare(logic [7:0] r, logic [7:0] m);
    logic [8:0] o;
    o = {1'b0, r} - {1'b0, m};
    put(alu65_pkg::FlagC, !o[8]);
    set_zn(o[7:0]);
  endfunction

  function logic [7:0] rotl(logic [7:0] m);
    logic c;
    c = get(alu65_pkg::FlagC);
    put(alu65_pkg::FlagC, m[7]);
    return {m[6:0], c};
  endfunction

  function logic [7:0] rotr(logic [7:0] m);
    logic c;
    c = get(alu65_pkg::FlagC);
    put(alu65_pkg::FlagC, m[0]);
    return {c, m[7:1]};
  endfunction

  function logic [7:0] shl(logic [7:0] m);
    put(alu65_pkg::FlagC, m[7]);
    return {m[6:0], 1'b0};
  endfunction

  function logic [7:0] shr(logic [7:0] m);
    put(alu65_pkg::FlagC, m[0]);
    return {1'b0, m[7:1]};
  endfunction

  // note an accepted request and queue the result it should give
  function void note_request(alu65_pkg::alu65_in_t req);
    import alu65_pkg::*;
    alu65_out_t r;
    logic [7:0] m, t;
    logic [15:0] ad, d16;
    logic take;
    m = req.data_in; ad = req.address_in; take = 0;
    case (req.opcode)
      OP_ADC: add_with_carry(m, 0);
      OP_AND: begin acc = acc & m; set_zn(acc); end
      OP_ASLA: begin acc = shl(acc); set_zn(acc); end
      OP_ASLM: begin m = shl(m); set_zn(m); end
      OP_BIT: begin
        put(FlagZ, (acc & m) == 0); put(FlagV, m[6]); put(FlagN, m[7]);
      end
      OP_CLC: put(FlagC, 0);
      OP_CLD: put(FlagD, 0);
      OP_CLI: put(FlagI, 0);
      OP_CLV: put(FlagV, 0);
      OP_CMP: compare(acc, m);
      OP_CPX: compare(rx, m);
      OP_CPY: compare(ry, m);
      OP_DEC: begin m = m - 1; set_zn(m); end
      OP_DEX: begin rx = rx - 1; set_zn(rx); end
      OP_DEY: begin ry = ry - 1; set_zn(ry); end
      OP_EOR: begin acc = acc ^ m; set_zn(acc); end
      OP_INC: begin m = m + 1; set_zn(m); end
      OP_INX: begin rx = rx + 1; set_zn(rx); end
      OP_INY: begin ry = ry + 1; set_zn(ry); end
      OP_LDA: begin acc = m; set_zn(m); end
      OP_LDX: begin rx = m; set_zn(m); end
      OP_LDY: begin ry = m; set_zn(m); end
      OP_LSRA: begin acc = shr(acc); set_zn(acc); end
      OP_LSRM: begin m = shr(m); set_zn(m); end
      OP_ORA: begin acc = acc | m; set_zn(acc); end
      OP_ROLA: begin acc = rotl(acc); set_zn(acc); end
      OP_ROLM: begin m = rotl(m); set_zn(m); end
      OP_RORA: begin acc = rotr(acc); set_zn(acc); end
      OP_RORM: begin m = rotr(m); set_zn(m); end
      OP_SBC: add_with_carry(~m, 1);
      OP_SEC: put(FlagC, 1);
      OP_SED: put(FlagD, 1);
      OP_SEI: put(FlagI, 1);
      OP_STA: m = acc;
      OP_STX: m = rx;
      OP_STY: m = ry;
      OP_TAX: begin rx = acc; set_zn(rx); end
      OP_TAY: begin ry = acc; set_zn(ry); end
      OP_TSX: begin rx = sp; set_zn(rx); end
      OP_TXA: begin acc = rx; set_zn(acc); end
      OP_TXS: sp = rx;
      OP_TYA: begin acc = ry; set_zn(acc); end
      OP_ANC: begin acc = acc & m; put(FlagC, acc[7]); set_zn(acc); end
      OP_SAX: m = acc & rx;
      OP_ANE: begin acc = rx & m; set_zn(acc); end
      OP_ARR: begin
        acc = {get(FlagC), 7'h0} | ((acc & m) >> 1);
        put(FlagC, acc[6]); set_zn(acc); put(FlagV, acc[6] ^ acc[5]);
      end
      OP_ASR: begin acc = shr(acc & m); set_zn(acc); end
      OP_ATX: begin acc = m; rx = m; set_zn(m); end
      OP_AXS: begin
        d16 = {8'h0, rx & acc} - {8'h0, m};
        put(FlagC, !d16[8]); rx = d16[7:0]; set_zn(rx);
      end
      OP_DCP: begin m = m - 1; compare(acc, m); end
      OP_ISC: begin m = m + 1; add_with_carry(~m, 1); end
      OP_LAS: begin t = m & sp; sp = t; acc = t; rx = t; set_zn(t); end
      OP_LAX: begin acc = m; rx = m; set_zn(m); end
      OP_RLA: begin m = rotl(m); acc = acc & m; set_zn(acc); end
      OP_RRA: begin m = rotr(m); add_with_carry(m, 0); end
      OP_SLO: begin m = shl(m); acc = acc | m; set_zn(acc); end
      OP_SRE: begin m = shr(m); acc = acc ^ m; set_zn(acc); end
      OP_SXA, OP_SYA: begin
        t = (req.opcode == OP_SXA) ? rx : ry;
        ad = {t & (ad[15:8] + 8'd1), ad[7:0]};
        m = ad[15:8];
      end
      OP_TAS: begin
        sp = acc & rx;
        d16 = ad - {8'h0, ry};
        m = acc & rx & (d16[15:8] + 8'd1);
      end
      OP_BCC: take = !get(FlagC);
      OP_BCS: take = get(FlagC);
      OP_BEQ: take = get(FlagZ);
      OP_BMI: take = get(FlagN);
      OP_BNE: take = !get(FlagZ);
      OP_BPL: take = !get(FlagN);
      OP_BVC: take = !get(FlagV);
      OP_BVS: take = get(FlagV);
      OP_PLP: flags = m & PMask;
      default: ;
    endcase
    r.acc_out = acc; r.x_out = rx; r.y_out = ry; r.stack_out = sp;
    r.status_out = (flags & PMask) | PFixed;
    r.data_out = m; r.address_out = ad; r.branch_taken = take;
    pending.push_back(r);
  endfunction

  // compare one result with the oldest expectation
  function void check_result(alu65_pkg::alu65_out_t got);
    alu65_pkg::alu65_out_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.acc_out !== got.acc_out)
      $display("%0t: acc exp %h got %h", $time, e.acc_out, got.acc_out);
    if (e.x_out !== got.x_out)
      $display("%0t: x exp %h got %h", $time, e.x_out, got.x_out);
    if (e.y_out !== got.y_out)
      $display("%0t: y exp %h got %h", $time, e.y_out, got.y_out);
    if (e.stack_out !== got.stack_out)
      $display("%0t: stack exp %h got %h", $time, e.stack_out, got.stack_out);
    if (e.status_out !== got.status_out)
      $display("%0t: status exp %h got %h", $time, e.status_out, got.status_out);
    if (e.data_out !== got.data_out)
      $display("%0t: data exp %h got %h", $time, e.data_out, got.data_out);
    if (e.address_out !== got.address_out)
      $display("%0t: address exp %h got %h", $time, e.address_out, got.address_out);
    if (e.branch_taken !== got.branch_taken)
      $display("%0t: branch exp %b got %b", $time, e.branch_taken, got.branch_taken);
    if (e !== got) errors++;
  endfunction
endclass

module eight_bit_cpu_alu_execute_tb;
  import alu65_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_valid, cfg_ready, cfg_data;
  alu65_in_t in_data;
  alu65_out_t out_data;
  int cycles;
  int hold_off;
  bit sending_done;
  alu65_scoreboard sb;

  eight_bit_cpu_alu_execute i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("eight_bit_cpu_alu_execute_tb: FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(0, 3) != 0) || sending_done;
  end

  // valid stays up between back-to-back requests, drops only over a gap
  task automatic send_request(logic [6:0] op, logic [7:0] d, logic [15:0] a);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, data_in: d, address_in: a};
    do @(posedge clk); while (!in_ready);
    sb.note_request(in_data);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_decimal_enable(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.dec_en = v;
    cfg_valid <= 1'b0;
  endtask

  // mostly valid operations, occasionally unused codes
  task automatic random_phase(int n);
    logic [6:0] op;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0) op = 7'($urandom_range(70, 127));
      else if ($urandom_range(0, 5) == 0) op = 7'($urandom_range(OP_ADC, OP_SBC)) & 7'h1f;
      else op = 7'($urandom_range(0, 69));
      if ($urandom_range(0, 4) == 0)
        send_request(op == OP_ADC ? OP_SED : op, 8'($urandom), 16'($urandom));
      else send_request(op, 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0; hold_off = 0; sending_done = 0;
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, decimal mode, stores, masking and branches
    send_request(OP_LDA, 8'h99, 16'h0000);
    send_request(OP_SED, 8'h00, 16'hffff);
    send_request(OP_ADC, 8'h01, 16'h1234);
    send_request(OP_SBC, 8'h00, 16'h1234);
    send_request(OP_ISC, 8'hff, 16'h0000);
    send_request(OP_RRA, 8'hff, 16'h0000);
    send_request(OP_ARR, 8'hff, 16'h0000);
    send_request(OP_CLD, 8'h00, 16'h0000);
    send_request(OP_ADC, 8'h7f, 16'h0000);
    send_request(OP_LDX, 8'h80, 16'h0000);
    send_request(OP_LDY, 8'hff, 16'hffff);
    send_request(OP_SXA, 8'h00, 16'hfeff);
    send_request(OP_SYA, 8'h00, 16'hffff);
    send_request(OP_TAS, 8'h00, 16'h0000);
    send_request(OP_ANE, 8'hff, 16'h0000);
    send_request(OP_ATX, 8'h55, 16'h0000);
    send_request(OP_AXS, 8'hff, 16'h0000);
    send_request(OP_LAS, 8'hff, 16'h0000);
    send_request(OP_PLP, 8'hff, 16'h0000);
    for (int b = OP_BCC; b <= OP_BVS; b++) send_request(b[6:0], 8'h00, 16'h0000);
    send_request(7'd127, 8'hff, 16'hffff);

    // every opcode once, then binary-only and back
    for (int o = 0; o <= 69; o++) send_request(o[6:0], 8'($urandom), 16'($urandom));
    write_decimal_enable(1'b0);
    random_phase(400);
    write_decimal_enable(1'b1);
    random_phase(400);

    // long receiver hold-off while requests keep coming
    drain();
    hold_off = 60;
    random_phase(200);
    drain();
    write_decimal_enable(1'b0);
    random_phase(300);
    write_decimal_enable(1'b1);
    random_phase(300);

    sending_done = 1;
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("eight_bit_cpu_alu_execute_tb: PASS");
    else
      $display("eight_bit_cpu_alu_execute_tb: FAIL");
    $finish;
  end
endmodule

// ----- eight_bit_cpu_alu_execute.f -----
hw/rtl/alu65_pkg.sv
hw/rtl/alu65_adder.sv
hw/rtl/eight_bit_cpu_alu_execute.sv
bench/eight_bit_cpu_alu_execute_tb.sv
